// ===== design/dtc_pkg.sv =====
// Shared constants, payload types and helpers for the distance trend classifier.
package dtc_pkg;

  // Burst store geometry
  localparam int MAX_SAMPLES = 32;
  localparam int SAMPLE_BITS = 12;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_BITS + 1;
  localparam int CMP_W       = 17;

  // Configuration registers
  localparam int DZ_W        = 8;
  localparam int JL_W        = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 1'b1;
  localparam logic [DZ_W-1:0] DEAD_ZONE_RST  = 8'd1;
  localparam logic [JL_W-1:0] JUMP_LIMIT_RST = 12'd50;

  // Result codes and counters
  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [1:0] TREND_STEADY  = 2'd0;
  localparam logic [1:0] TREND_RISING  = 2'd1;
  localparam logic [1:0] TREND_FALLING = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] distance_sample;
    logic                   burst_end;
  } dtc_in_t;

  typedef struct packed {
    logic [1:0]         trend;
    logic [COUNT_W-1:0] rise_count;
    logic [COUNT_W-1:0] fall_count;
    logic [COUNT_W-1:0] steady_count;
    logic               too_few;
    logic               overflowed;
  } dtc_out_t;

  // Saturating step counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/dtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/distance_trend_classifier.sv =====
// Distance trend classifier: burst store, three-pass scan sequencer and result register.
//
//  channel | ports                        | transfer
//  --------+------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data  | one distance sample per transaction
//  result  | out_valid, out_ready, out_data | one class per burst
//  config  | cfg_we, cfg_index, cfg_wdata | register write, no wait
//
// A burst end of n stored samples (n >= 3) runs three passes over the sample RAM
// (minimum, maximum, pair walk), each through the single registered read port,
// then loads the result. A short burst goes straight to the final state.
// in_ready is high only while the sequencer idles; a result waiting on out_ready
// holds the sequencer in its final state. Reset is synchronous and needs no sweep.
module distance_trend_classifier
  import dtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtc_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIN  = 3'd1;
  localparam logic [2:0] S_MAX  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       n_r;
  logic                   ovf_r;
  logic                   too_few_r;
  logic [CNT_W-1:0]       a_r;
  logic                   d_vld_r;
  logic [IDX_W-1:0]       d_idx_r;
  logic [DZ_W-1:0]        dead_zone_r;
  logic [JL_W-1:0]        jump_limit_r;
  logic [IDX_W-1:0]       lo_idx_r, hi_idx_r;
  logic [SAMPLE_BITS-1:0] lo_val_r, hi_val_r, prev_r;
  logic                   have_hi_r, have_prev_r;
  logic [COUNT_W-1:0]     rise_r, fall_r, steady_r;
  logic                   out_valid_r;
  dtc_out_t               out_data_r;

  logic                   in_fire, has_room, ram_we;
  logic                   scanning, issue, pass_last, fin_fire;
  logic [CNT_W-1:0]       n_acc;
  logic [SAMPLE_BITS-1:0] rdata, diff;
  logic [CMP_W-1:0]       diff_x, jl_x;
  logic [SUM_W-1:0]       cur_dz, prev_dz;
  logic                   keep, step_ok, is_fall, is_rise;
  logic [1:0]             trend_fin;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign has_room  = (n_r < CNT_W'(MAX_SAMPLES));
  assign ram_we    = in_fire && has_room;
  assign n_acc     = has_room ? n_r + 1'b1 : n_r;
  assign scanning  = (state_r == S_MIN) || (state_r == S_MAX) || (state_r == S_WALK);
  assign issue     = scanning && (a_r < n_r);
  assign pass_last = d_vld_r && ({1'b0, d_idx_r} == n_r - 1'b1);
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  dtc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n_r[IDX_W-1:0]),
    .wdata (in_data.distance_sample),
    .raddr (a_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Shared step comparator for the pair walk
  assign diff    = (rdata >= prev_r) ? rdata - prev_r : prev_r - rdata;
  assign diff_x  = CMP_W'(diff);
  assign jl_x    = CMP_W'(jump_limit_r);
  assign cur_dz  = SUM_W'(rdata) + SUM_W'(dead_zone_r);
  assign prev_dz = SUM_W'(prev_r) + SUM_W'(dead_zone_r);
  assign keep    = (d_idx_r != lo_idx_r) && (d_idx_r != hi_idx_r);
  assign step_ok = (diff_x <= jl_x);
  assign is_fall = (cur_dz < SUM_W'(prev_r));
  assign is_rise = (prev_dz < SUM_W'(rdata));

  // Pick the class from the step counts
  always_comb begin
    trend_fin = TREND_STEADY;
    if ((steady_r < rise_r) || (steady_r < fall_r)) begin
      trend_fin = (rise_r > fall_r) ? TREND_RISING : TREND_FALLING;
    end
  end

  // Sequence load, three passes and result hand-off
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.burst_end) begin
          state_nxt = (n_acc < CNT_W'(3)) ? S_FIN : S_MIN;
        end
      end
      S_MIN:  if (pass_last) state_nxt = S_MAX;
      S_MAX:  if (pass_last) state_nxt = S_WALK;
      S_WALK: if (pass_last) state_nxt = S_FIN;
      S_FIN:  if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= '0;
      ovf_r        <= 1'b0;
      a_r          <= '0;
      d_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      dead_zone_r  <= DEAD_ZONE_RST;
      jump_limit_r <= JUMP_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        n_r <= n_acc;
        if (!has_room) begin
          ovf_r <= 1'b1;
        end
      end
      if (fin_fire) begin
        n_r   <= '0;
        ovf_r <= 1'b0;
      end
      // Advance the read pointer, restart it at each pass boundary
      if (pass_last) begin
        a_r     <= '0;
        d_vld_r <= 1'b0;
      end else begin
        if (issue) begin
          a_r <= a_r + 1'b1;
        end
        d_vld_r <= issue;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEAD_ZONE:  dead_zone_r  <= cfg_wdata[DZ_W-1:0];
          REG_JUMP_LIMIT: jump_limit_r <= cfg_wdata[JL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    d_idx_r <= a_r[IDX_W-1:0];
    if (in_fire && in_data.burst_end) begin
      too_few_r   <= (n_acc < CNT_W'(3));
      rise_r      <= '0;
      fall_r      <= '0;
      steady_r    <= '0;
      have_hi_r   <= 1'b0;
      have_prev_r <= 1'b0;
    end
    // Minimum pass: first smallest sample
    if ((state_r == S_MIN) && d_vld_r) begin
      if ((d_idx_r == '0) || (rdata < lo_val_r)) begin
        lo_idx_r <= d_idx_r;
        lo_val_r <= rdata;
      end
    end
    // Maximum pass: first largest of the rest
    if ((state_r == S_MAX) && d_vld_r && (d_idx_r != lo_idx_r)) begin
      if (!have_hi_r || (rdata > hi_val_r)) begin
        hi_idx_r  <= d_idx_r;
        hi_val_r  <= rdata;
        have_hi_r <= 1'b1;
      end
    end
    // Pair walk: drop glitches, count falls, rises and steady steps
    if ((state_r == S_WALK) && d_vld_r && keep) begin
      if (!have_prev_r) begin
        prev_r      <= rdata;
        have_prev_r <= 1'b1;
      end else if (step_ok) begin
        prev_r <= rdata;
        if (is_fall) begin
          fall_r <= sat_inc(fall_r);
        end else if (is_rise) begin
          rise_r <= sat_inc(rise_r);
        end else begin
          steady_r <= sat_inc(steady_r);
        end
      end
    end
    // Load the result register
    if (fin_fire) begin
      out_data_r.trend        <= too_few_r ? TREND_STEADY : trend_fin;
      out_data_r.rise_count   <= too_few_r ? '0 : rise_r;
      out_data_r.fall_count   <= too_few_r ? '0 : fall_r;
      out_data_r.steady_count <= too_few_r ? '0 : steady_r;
      out_data_r.too_few      <= too_few_r;
      out_data_r.overflowed   <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result appears only after the final state
  a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the final state");

  // A short burst reports no steps and a steady class
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.too_few) |->
      (out_data.rise_count == '0 && out_data.fall_count == '0 &&
       out_data.steady_count == '0 && out_data.trend == TREND_STEADY))
    else $error("short burst carried nonzero counts");

  // The stored count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // Scans never read past the stored samples
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> ({1'b0, d_idx_r} < n_r))
    else $error("scan read beyond burst");

endmodule
